// File: sv/intel_hex_record_checker_assert.svh
// Assertion macros shared by the Intel HEX record checker RTL.
`ifndef INTEL_HEX_RECORD_CHECKER_ASSERT_SVH
`define INTEL_HEX_RECORD_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ihc_pkg.sv
// Package with codes, types and helper functions of the Intel HEX record checker.
package ihc_pkg;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int FPOS_W     = 10;

  localparam logic [CFG_ADDR_W-1:0] REG_APP_BASE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_APP_END  = 1'b1;

  localparam logic [31:0] APP_BASE_RESET = 32'd134348800;
  localparam logic [31:0] APP_END_RESET  = 32'd136314880;
  localparam logic [31:0] MIN_SEEN_RESET = 32'hFFFF_FFFF;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_DATA   = 3'd1;
  localparam logic [2:0] EV_ACCEPT = 3'd2;
  localparam logic [2:0] EV_DONE   = 3'd3;
  localparam logic [2:0] EV_ERROR  = 3'd4;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FORMAT = 2'd1;
  localparam logic [1:0] ERR_RANGE  = 2'd2;

  localparam logic [7:0] CHAR_COLON    = 8'h3A;
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_LIN   = 8'h04;
  localparam logic [7:0] EXT_LIN_COUNT = 8'd2;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  data_byte;
    logic [31:0] byte_addr;
    logic [1:0]  error_code;
    logic [31:0] low_addr;
    logic [31:0] high_addr;
  } res_t;

  // Returns {valid, nibble} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = '0;
    case (ch) inside
      [8'h30:8'h39]:                r = {1'b1, ch[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, ch[3:0] + 4'd9};
      default:                      r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/ihc_cfg_regs.sv
// Configuration registers holding the allowed application address window.
module ihc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ihc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ihc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [31:0]                    app_base,
  output logic [31:0]                    app_end
);

  logic [31:0] app_base_r, app_base_nxt;
  logic [31:0] app_end_r,  app_end_nxt;

  always_comb begin
    app_base_nxt = app_base_r;
    app_end_nxt  = app_end_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        ihc_pkg::REG_APP_BASE: app_base_nxt = cfg_wdata;
        ihc_pkg::REG_APP_END:  app_end_nxt  = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_base_r <= ihc_pkg::APP_BASE_RESET;
      app_end_r  <= ihc_pkg::APP_END_RESET;
    end else begin
      app_base_r <= app_base_nxt;
      app_end_r  <= app_end_nxt;
    end
  end

  assign app_base = app_base_r;
  assign app_end  = app_end_r;

endmodule

// File: sv/ihc_step.sv
// Record parser state and the per-character decode, check and result logic.
module ihc_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [7:0]         ch,
  input  logic               last,
  input  logic [31:0]        app_base,
  input  logic [31:0]        app_end,
  output ihc_pkg::res_t      res
);

  localparam int FW = ihc_pkg::FPOS_W;

  logic [FW-1:0] field_pos_r,    field_pos_nxt;
  logic [3:0]    nibble_latch_r, nibble_latch_nxt;
  logic [7:0]    rec_count_r,    rec_count_nxt;
  logic [15:0]   rec_offset_r,   rec_offset_nxt;
  logic [7:0]    rec_type_r,     rec_type_nxt;
  logic [7:0]    run_sum_r,      run_sum_nxt;
  logic [15:0]   upper_addr_r,   upper_addr_nxt;
  logic [7:0]    ext_hi_byte_r,  ext_hi_byte_nxt;
  logic [31:0]   min_seen_r,     min_seen_nxt;
  logic [31:0]   max_seen_r,     max_seen_nxt;
  logic          stopped_r,      stopped_nxt;

  logic [4:0]    hex;
  logic [FW-1:0] k;
  logic [FW-2:0] idx;
  logic [7:0]    pair_byte;
  logic [7:0]    sum_next;
  logic [7:0]    di;
  logic [31:0]   rec_addr;
  logic [31:0]   data_addr;
  logic [32:0]   end_addr;
  logic          range_bad;
  logic [FW-2:0] data_end;

  assign hex       = ihc_pkg::hex_decode(ch);
  assign k         = field_pos_r - FW'(1);
  assign idx       = k[FW-1:1];
  assign pair_byte = {nibble_latch_r, hex[3:0]};
  assign sum_next  = run_sum_r + pair_byte;
  // Data bytes sit at pair index 4 onward; the index stays below 259 there.
  assign di        = idx[7:0] - 8'd4;
  assign rec_addr  = {upper_addr_r, rec_offset_r};
  assign data_addr = rec_addr + {24'd0, di};
  assign end_addr  = {1'b0, rec_addr} + {25'd0, rec_count_r};
  assign range_bad = (rec_addr < app_base) || end_addr[32] ||
                     (end_addr > {1'b0, app_end});
  assign data_end  = (FW-1)'(rec_count_r) + (FW-1)'(4);

  always_comb begin
    field_pos_nxt    = field_pos_r;
    nibble_latch_nxt = nibble_latch_r;
    rec_count_nxt    = rec_count_r;
    rec_offset_nxt   = rec_offset_r;
    rec_type_nxt     = rec_type_r;
    run_sum_nxt      = run_sum_r;
    upper_addr_nxt   = upper_addr_r;
    ext_hi_byte_nxt  = ext_hi_byte_r;
    min_seen_nxt     = min_seen_r;
    max_seen_nxt     = max_seen_r;
    stopped_nxt      = stopped_r;
    res              = '0;
    res.ev           = ihc_pkg::EV_NONE;

    if (!stopped_r) begin
      if (field_pos_r == '0) begin
        if (ch == ihc_pkg::CHAR_COLON) begin
          field_pos_nxt  = FW'(1);
          run_sum_nxt    = '0;
          rec_count_nxt  = '0;
          rec_offset_nxt = '0;
          rec_type_nxt   = '0;
        end
      end else if (!hex[4]) begin
        res.ev         = ihc_pkg::EV_ERROR;
        res.error_code = ihc_pkg::ERR_FORMAT;
        stopped_nxt    = 1'b1;
        field_pos_nxt  = '0;
      end else begin
        field_pos_nxt = field_pos_r + FW'(1);
        if (!k[0]) begin
          nibble_latch_nxt = hex[3:0];
        end else begin
          run_sum_nxt = sum_next;
          if (idx == (FW-1)'(0)) begin
            rec_count_nxt = pair_byte;
          end else if (idx == (FW-1)'(1)) begin
            rec_offset_nxt = {pair_byte, 8'd0};
          end else if (idx == (FW-1)'(2)) begin
            rec_offset_nxt = {rec_offset_r[15:8], pair_byte};
          end else if (idx == (FW-1)'(3)) begin
            rec_type_nxt = pair_byte;
          end else if (idx < data_end) begin
            if (rec_type_r == ihc_pkg::REC_DATA) begin
              res.ev        = ihc_pkg::EV_DATA;
              res.data_byte = pair_byte;
              res.byte_addr = data_addr;
            end else if (rec_type_r == ihc_pkg::REC_EXT_LIN) begin
              if (di == 8'd0) begin
                ext_hi_byte_nxt = pair_byte;
              end else if (di == 8'd1) begin
                rec_offset_nxt = {ext_hi_byte_r, pair_byte};
              end
            end
          end else begin
            // Checksum pair: judge the whole record.
            field_pos_nxt = '0;
            res.ev        = ihc_pkg::EV_ACCEPT;
            if (sum_next != 8'd0) begin
              res.ev         = ihc_pkg::EV_ERROR;
              res.error_code = ihc_pkg::ERR_FORMAT;
              stopped_nxt    = 1'b1;
            end else if (rec_type_r == ihc_pkg::REC_DATA) begin
              if (rec_count_r != 8'd0) begin
                if (range_bad) begin
                  res.ev         = ihc_pkg::EV_ERROR;
                  res.error_code = ihc_pkg::ERR_RANGE;
                  stopped_nxt    = 1'b1;
                end else begin
                  if (rec_addr < min_seen_r) min_seen_nxt = rec_addr;
                  if (end_addr[31:0] > max_seen_r) max_seen_nxt = end_addr[31:0];
                end
              end
            end else if (rec_type_r == ihc_pkg::REC_EOF) begin
              stopped_nxt = 1'b1;
              if (min_seen_r == ihc_pkg::MIN_SEEN_RESET) begin
                res.ev         = ihc_pkg::EV_ERROR;
                res.error_code = ihc_pkg::ERR_FORMAT;
              end else begin
                res.ev        = ihc_pkg::EV_DONE;
                res.low_addr  = min_seen_r;
                res.high_addr = max_seen_r;
              end
            end else if (rec_type_r == ihc_pkg::REC_EXT_LIN) begin
              if (rec_count_r != ihc_pkg::EXT_LIN_COUNT) begin
                res.ev         = ihc_pkg::EV_ERROR;
                res.error_code = ihc_pkg::ERR_FORMAT;
                stopped_nxt    = 1'b1;
              end else begin
                upper_addr_nxt = rec_offset_r;
              end
            end
          end
        end
      end
    end

    if (last) begin
      // An image that ends without completing is a format error.
      if (!stopped_r && res.ev != ihc_pkg::EV_DONE && res.ev != ihc_pkg::EV_ERROR) begin
        res            = '0;
        res.ev         = ihc_pkg::EV_ERROR;
        res.error_code = ihc_pkg::ERR_FORMAT;
      end
      field_pos_nxt    = '0;
      nibble_latch_nxt = '0;
      rec_count_nxt    = '0;
      rec_offset_nxt   = '0;
      rec_type_nxt     = '0;
      run_sum_nxt      = '0;
      upper_addr_nxt   = '0;
      ext_hi_byte_nxt  = '0;
      min_seen_nxt     = ihc_pkg::MIN_SEEN_RESET;
      max_seen_nxt     = '0;
      stopped_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_pos_r    <= '0;
      nibble_latch_r <= '0;
      rec_count_r    <= '0;
      rec_offset_r   <= '0;
      rec_type_r     <= '0;
      run_sum_r      <= '0;
      upper_addr_r   <= '0;
      ext_hi_byte_r  <= '0;
      min_seen_r     <= ihc_pkg::MIN_SEEN_RESET;
      max_seen_r     <= '0;
      stopped_r      <= 1'b0;
    end else if (en) begin
      field_pos_r    <= field_pos_nxt;
      nibble_latch_r <= nibble_latch_nxt;
      rec_count_r    <= rec_count_nxt;
      rec_offset_r   <= rec_offset_nxt;
      rec_type_r     <= rec_type_nxt;
      run_sum_r      <= run_sum_nxt;
      upper_addr_r   <= upper_addr_nxt;
      ext_hi_byte_r  <= ext_hi_byte_nxt;
      min_seen_r     <= min_seen_nxt;
      max_seen_r     <= max_seen_nxt;
      stopped_r      <= stopped_nxt;
    end
  end

endmodule

// File: sv/intel_hex_record_checker.sv
// A character accepted by the input register moves on to the output register, where its
// result is registered and out_tvalid rises; a stall on the output can come between.
// Throughput: one character per cycle, stalled only while out_tready is low; the parser
// state updates as the input register hands its character to the output register.
// Reset (rst_n low, synchronous) empties both registers, returns the parser to hunting
// for a colon and loads the default application address window.
module intel_hex_record_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] char_in
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] data_byte, [39:8] byte_addr, [41:40] error_code, [73:42] low_addr,
  // [105:74] high_addr, [111:106] zero
  output logic [111:0]                   out_tdata,
  output logic [2:0]                     out_tuser,  // [2:0] event_res
  input  logic                           cfg_we,
  input  logic [ihc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ihc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

`include "intel_hex_record_checker_assert.svh"

  logic          in_v_r, in_v_nxt;
  logic [7:0]    in_char_r;
  logic          in_last_r;
  logic          res_v_r, res_v_nxt;
  ihc_pkg::res_t res_r;
  ihc_pkg::res_t step_res;
  logic          advance;
  logic          take_in;
  logic [31:0]   app_base;
  logic [31:0]   app_end;

  assign advance   = in_v_r && (!res_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign take_in   = in_tvalid && in_tready;

  ihc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .app_base  (app_base),
    .app_end   (app_end)
  );

  ihc_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .ch       (in_char_r),
    .last     (in_last_r),
    .app_base (app_base),
    .app_end  (app_end),
    .res      (step_res)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (take_in) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
    res_v_nxt = res_v_r;
    if (advance) begin
      res_v_nxt = 1'b1;
    end else if (out_tready) begin
      res_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = res_v_r;
  assign out_tuser  = res_r.ev;
  assign out_tdata  = {6'd0, res_r.high_addr, res_r.low_addr, res_r.error_code,
                       res_r.byte_addr, res_r.data_byte};

  `IHC_ASSERT_SAME(a_err_only_on_error,
    res_v_r && res_r.ev != ihc_pkg::EV_ERROR, res_r.error_code == ihc_pkg::ERR_NONE,
    "error code set on a non-error result")
  `IHC_ASSERT_SAME(a_error_has_code,
    res_v_r && res_r.ev == ihc_pkg::EV_ERROR, res_r.error_code != ihc_pkg::ERR_NONE,
    "error result without an error code")
  `IHC_ASSERT_SAME(a_data_fields_zero,
    res_v_r && res_r.ev != ihc_pkg::EV_DATA, res_r.data_byte == 8'd0 && res_r.byte_addr == 32'd0,
    "data fields set on a non-data result")
  `IHC_ASSERT_NEXT(a_input_held,
    in_v_r && !advance, in_v_r && $stable(in_char_r) && $stable(in_last_r),
    "input register lost a stalled character")

endmodule

// File: tb/tb_intel_hex_record_checker.sv
// Self-checking testbench for the Intel HEX record checker: directed images, random images, stalls.
module tb_intel_hex_record_checker;
  import ihc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_LIMIT    = 1000;
  localparam int LONG_HOLD      = 300;

  typedef enum int {CASE_UPPER, CASE_LOWER, CASE_MIXED} glyph_case_e;
  typedef enum int {RX_FREE, RX_HALF, RX_PATTERN, RX_SPARSE} rx_pace_e;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = 8'h00;  // [7:0] char_in
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [7:0] data_byte, [39:8] byte_addr, [41:40] error_code, [73:42] low_addr,
  // [105:74] high_addr, [111:106] zero
  logic [111:0]          out_tdata;
  logic [2:0]            out_tuser;           // [2:0] event_res
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  always #1 clk = ~clk;

  intel_hex_record_checker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Parser state of the predictor.
  logic [FPOS_W-1:0] p_pos;
  logic [3:0]        p_nib;
  logic [7:0]        p_count;
  logic [15:0]       p_offset;
  logic [7:0]        p_type;
  logic [7:0]        p_sum;
  logic [15:0]       p_upper;
  logic [7:0]        p_ext_hi;
  logic [31:0]       p_min;
  logic [31:0]       p_max;
  logic              p_halted;
  logic [31:0]       win_base = APP_BASE_RESET;
  logic [31:0]       win_end  = APP_END_RESET;

  res_t pending_results[$];

  int error_count  = 0;
  int chars_sent   = 0;
  int images_sent  = 0;
  int windows_used = 1;
  int n_data = 0, n_accept = 0, n_done = 0, n_fmt = 0, n_range = 0;

  // Image under construction.
  logic [7:0]  img[$];
  logic [7:0]  payload[$];
  glyph_case_e glyph_case = CASE_UPPER;
  logic [15:0] gen_upper;

  // Sender and receiver pacing.
  int       burst_left = 0;
  bit       hold_req   = 1'b0;
  int       hold_left  = 0;
  rx_pace_e rx_pace    = RX_FREE;
  int       pace_left  = 0;
  logic [3:0] rx_tick  = 4'h0;

  function automatic bit hex_digit(input logic [7:0] ch, output logic [3:0] val);
    val = 4'h0;
    if (ch >= 8'h30 && ch <= 8'h39) val = 4'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h46) val = 4'(ch - 8'h37);
    else if (ch >= 8'h61 && ch <= 8'h66) val = 4'(ch - 8'h57);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_parser();
    p_pos    = '0;
    p_nib    = 4'h0;
    p_count  = 8'h00;
    p_offset = 16'h0000;
    p_type   = 8'h00;
    p_sum    = 8'h00;
    p_upper  = 16'h0000;
    p_ext_hi = 8'h00;
    p_min    = MIN_SEEN_RESET;
    p_max    = 32'h0000_0000;
    p_halted = 1'b0;
  endfunction

  // Judges a complete record at its checksum byte.
  function automatic res_t close_record();
    res_t        r;
    logic [31:0] start_addr;
    logic [32:0] stop_addr;
    r = '0;
    start_addr = {p_upper, 16'h0000} + {16'h0000, p_offset};
    stop_addr  = {1'b0, start_addr} + {25'd0, p_count};
    p_pos = '0;
    if (p_sum != 8'h00) begin
      r.ev = EV_ERROR;
      r.error_code = ERR_FORMAT;
      p_halted = 1'b1;
    end else if (p_type == REC_DATA) begin
      r.ev = EV_ACCEPT;
      if (p_count != 8'h00) begin
        if (start_addr < win_base || stop_addr[32] || stop_addr > {1'b0, win_end}) begin
          r.ev = EV_ERROR;
          r.error_code = ERR_RANGE;
          p_halted = 1'b1;
        end else begin
          if (start_addr < p_min) p_min = start_addr;
          if (stop_addr[31:0] > p_max) p_max = stop_addr[31:0];
        end
      end
    end else if (p_type == REC_EOF) begin
      p_halted = 1'b1;
      if (p_min == MIN_SEEN_RESET) begin
        r.ev = EV_ERROR;
        r.error_code = ERR_FORMAT;
      end else begin
        r.ev = EV_DONE;
        r.low_addr = p_min;
        r.high_addr = p_max;
      end
    end else if (p_type == REC_EXT_LIN && p_count != EXT_LIN_COUNT) begin
      r.ev = EV_ERROR;
      r.error_code = ERR_FORMAT;
      p_halted = 1'b1;
    end else begin
      if (p_type == REC_EXT_LIN) p_upper = p_offset;
      r.ev = EV_ACCEPT;
    end
    return r;
  endfunction

  function automatic res_t predict_char(input logic [7:0] ch, input logic lst);
    res_t              r;
    logic              was_halted;
    logic              ok;
    logic [3:0]        nib;
    logic [FPOS_W-1:0] k;
    logic [7:0]        b;
    int                idx;
    r = '0;
    was_halted = p_halted;
    if (!was_halted) begin
      if (p_pos == '0) begin
        if (ch == CHAR_COLON) begin
          p_pos    = FPOS_W'(1);
          p_sum    = 8'h00;
          p_count  = 8'h00;
          p_offset = 16'h0000;
          p_type   = 8'h00;
        end
      end else begin
        ok = hex_digit(ch, nib);
        if (!ok) begin
          r.ev = EV_ERROR;
          r.error_code = ERR_FORMAT;
          p_halted = 1'b1;
          p_pos = '0;
        end else begin
          k = p_pos - FPOS_W'(1);
          p_pos = p_pos + FPOS_W'(1);
          if (!k[0]) begin
            p_nib = nib;
          end else begin
            b = {p_nib, nib};
            idx = int'(k >> 1);
            p_sum = p_sum + b;
            if (idx == 0) p_count = b;
            else if (idx == 1) p_offset = {b, 8'h00};
            else if (idx == 2) p_offset = p_offset | {8'h00, b};
            else if (idx == 3) p_type = b;
            else if (idx < 4 + int'(p_count)) begin
              if (p_type == REC_DATA) begin
                r.ev = EV_DATA;
                r.data_byte = b;
                r.byte_addr = {p_upper, 16'h0000} + {16'h0000, p_offset} + 32'(idx - 4);
              end else if (p_type == REC_EXT_LIN) begin
                if (idx == 4) p_ext_hi = b;
                else if (idx == 5) p_offset = {p_ext_hi, b};
              end
            end else begin
              r = close_record();
            end
          end
        end
      end
    end
    if (lst) begin
      // The final character flags a missing end record unless it settled the image itself.
      if (!was_halted && r.ev != EV_DONE && r.ev != EV_ERROR) begin
        r = '0;
        r.ev = EV_ERROR;
        r.error_code = ERR_FORMAT;
      end
      clear_parser();
    end
    return r;
  endfunction

  // Result checking and prediction, both sampled at the falling edge where all signals are stable.
  always @(negedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.ev         = out_tuser;
        got.data_byte  = out_tdata[7:0];
        got.byte_addr  = out_tdata[39:8];
        got.error_code = out_tdata[41:40];
        got.low_addr   = out_tdata[73:42];
        got.high_addr  = out_tdata[105:74];
        case (got.ev)
          EV_DATA:   n_data++;
          EV_ACCEPT: n_accept++;
          EV_DONE:   n_done++;
          EV_ERROR:  if (got.error_code == ERR_RANGE) n_range++; else n_fmt++;
          default:   ;
        endcase
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result transaction, event %0d", got.ev);
        end else begin
          want = pending_results.pop_front();
          if (got.ev !== want.ev || got.data_byte !== want.data_byte ||
              got.byte_addr !== want.byte_addr || got.error_code !== want.error_code ||
              got.low_addr !== want.low_addr || got.high_addr !== want.high_addr) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch (expected/actual): ev %0d/%0d byte %h/%h addr %h/%h",
                       want.ev, got.ev, want.data_byte, got.data_byte,
                       want.byte_addr, got.byte_addr);
              $display("  err %0d/%0d low %h/%h high %h/%h",
                       want.error_code, got.error_code, want.low_addr, got.low_addr,
                       want.high_addr, got.high_addr);
            end
          end
        end
      end
      if (in_tvalid && in_tready) pending_results.push_back(predict_char(in_tdata, in_tlast));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_intel_hex_record_checker failed");
    $finish;
  end

  // Receiver pacing; a requested hold-off is counted down here.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 4'h1;
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (pace_left == 0) begin
      rx_pace = rx_pace_e'($urandom_range(0, 3));
      pace_left = $urandom_range(20, 200);
    end else begin
      pace_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_pace)
        RX_FREE:    out_tready <= 1'b1;
        RX_HALF:    out_tready <= ($urandom_range(0, 1) == 1);
        RX_PATTERN: out_tready <= (rx_tick < 4'd11);
        default:    out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offers one character and returns at the edge that accepts it, leaving it driven.
  task automatic send_char(input logic [7:0] ch, input logic lst);
    int  gap;
    bit  steady;
    if (burst_left == 0) begin
      steady = ($urandom_range(0, 4) == 0);
      burst_left = steady ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= lst;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    chars_sent++;
  endtask

  task automatic sender_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    sender_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_APP_BASE) win_base = val;
    else win_end = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_image();
    for (int i = 0; i < img.size(); i++) send_char(img[i], i == img.size() - 1);
    images_sent++;
  endtask

  function automatic logic [7:0] hex_glyph(input logic [3:0] n);
    bit lower;
    lower = (glyph_case == CASE_LOWER) ||
            (glyph_case == CASE_MIXED && $urandom_range(0, 1) == 1);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (lower ? 8'h57 : 8'h37) + {4'h0, n};
  endfunction

  function automatic logic [7:0] bad_glyph();
    logic [7:0] c;
    logic [3:0] v;
    if ($urandom_range(0, 3) == 0) return CHAR_COLON;
    do c = 8'($urandom_range(0, 255)); while (hex_digit(c, v));
    return c;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    img.push_back(hex_glyph(b[7:4]));
    img.push_back(hex_glyph(b[3:0]));
  endfunction

  function automatic void put_noise(input int n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON);
      img.push_back(c);
    end
  endfunction

  function automatic void fill_payload(input int n);
    payload.delete();
    repeat (n) payload.push_back(8'($urandom));
  endfunction

  // Appends one record carrying the payload; a bad checksum is made on request.
  function automatic void put_record(input logic [7:0] rtype, input logic [15:0] offs,
                                     input bit bad_sum);
    logic [7:0] cnt;
    logic [7:0] sum;
    cnt = 8'(payload.size());
    img.push_back(CHAR_COLON);
    put_byte(cnt);
    put_byte(offs[15:8]);
    put_byte(offs[7:0]);
    put_byte(rtype);
    sum = cnt + offs[15:8] + offs[7:0] + rtype;
    foreach (payload[i]) begin
      put_byte(payload[i]);
      sum = sum + payload[i];
    end
    sum = -sum;
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    put_byte(sum);
  endfunction

  function automatic void put_ext(input logic [15:0] upper);
    payload.delete();
    payload.push_back(upper[15:8]);
    payload.push_back(upper[7:0]);
    put_record(REC_EXT_LIN, 16'($urandom), 1'b0);
    gen_upper = upper;
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 199);
    if (r == 0) return 255;
    if (r < 170) return $urandom_range(1, 16);
    return $urandom_range(17, 40);
  endfunction

  // Data record placed inside the current window when the window is wide enough.
  function automatic void put_window_data(input int cnt);
    logic [32:0] span;
    logic [31:0] a;
    span = {1'b0, win_end} - {1'b0, win_base};
    if (win_end > win_base && span >= 33'(cnt)) begin
      case ($urandom_range(0, 3))
        0:       a = win_base;
        1:       a = win_end - 32'(cnt);
        default: a = win_base + 32'(33'($urandom) % (span - 33'(cnt) + 33'd1));
      endcase
    end else begin
      a = $urandom;
    end
    if (a[31:16] != gen_upper || $urandom_range(0, 3) == 0) put_ext(a[31:16]);
    fill_payload(cnt);
    put_record(REC_DATA, a[15:0], 1'b0);
  endfunction

  function automatic logic [7:0] other_type();
    logic [7:0] t;
    do t = 8'($urandom_range(0, 255));
    while (t == REC_DATA || t == REC_EOF || t == REC_EXT_LIN);
    return t;
  endfunction

  // Mostly well-formed images, with a sprinkling of broken records, noise and truncation.
  function automatic void gen_image();
    int kind;
    int start;
    int n;
    img.delete();
    gen_upper = 16'h0000;
    glyph_case = glyph_case_e'($urandom_range(0, 2));
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 2) == 0) put_noise($urandom_range(1, 4));
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        put_window_data(pick_count());
      end else if (kind < 60) begin
        put_ext($urandom_range(0, 1) == 1 ? win_base[31:16] : 16'($urandom));
      end else if (kind < 66) begin
        payload.delete();
        put_record(REC_DATA, 16'($urandom), 1'b0);
      end else if (kind < 72) begin
        fill_payload($urandom_range(0, 4));
        put_record(other_type(), 16'($urandom), 1'b0);
      end else if (kind < 74) begin
        fill_payload($urandom_range(0, 1) == 1 ? $urandom_range(0, 1) : $urandom_range(3, 4));
        put_record(REC_EXT_LIN, 16'($urandom), 1'b0);
      end else if (kind < 77) begin
        fill_payload(pick_count());
        put_record(REC_DATA, 16'($urandom), 1'b0);
      end else if (kind < 80) begin
        fill_payload($urandom_range(0, 8));
        put_record($urandom_range(0, 1) == 1 ? REC_DATA : REC_EXT_LIN, 16'($urandom), 1'b1);
      end else if (kind < 83) begin
        start = img.size();
        put_window_data($urandom_range(1, 8));
        img[$urandom_range(start + 1, img.size() - 1)] = bad_glyph();
      end else begin
        put_window_data(pick_count());
      end
    end
    if ($urandom_range(0, 19) != 0) begin
      fill_payload($urandom_range(0, 9) == 0 ? 1 : 0);
      put_record(REC_EOF, 16'($urandom), $urandom_range(0, 29) == 0);
    end
    if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 6));
    if ($urandom_range(0, 9) == 0) put_window_data(2);
    if ($urandom_range(0, 14) == 0) begin
      n = $urandom_range(1, 8);
      while (n > 0 && img.size() > 1) begin
        void'(img.pop_back());
        n--;
      end
    end
  endfunction

  task automatic test_clean_image();
    glyph_case = CASE_MIXED;
    img.delete();
    img.push_back(8'h00);
    img.push_back(8'hFF);
    put_ext(APP_BASE_RESET[31:16]);
    payload.delete();
    payload.push_back(8'h00);
    payload.push_back(8'hFF);
    payload.push_back(8'hA5);
    payload.push_back(8'h5A);
    put_record(REC_DATA, 16'h0000, 1'b0);
    payload.delete();
    put_record(REC_DATA, 16'hFFFF, 1'b0);
    payload.push_back(8'h12);
    put_record(8'h03, 16'h1234, 1'b0);
    payload.delete();
    put_record(REC_EOF, 16'h0000, 1'b0);
    send_image();
  endtask

  task automatic test_record_errors();
    glyph_case = CASE_UPPER;
    // A colon inside a record; the characters after it meet a stopped parser.
    img.delete();
    img.push_back(CHAR_COLON);
    img.push_back(8'h30);
    img.push_back(CHAR_COLON);
    img.push_back(8'h30);
    img.push_back(8'h30);
    send_image();
    img.delete();
    payload.delete();
    put_record(REC_DATA, 16'h0000, 1'b1);
    img.push_back(8'h78);
    send_image();
    img.delete();
    payload.delete();
    payload.push_back(8'h08);
    put_record(REC_EXT_LIN, 16'h0000, 1'b0);
    send_image();
    img.delete();
    payload.delete();
    put_record(REC_EOF, 16'h0000, 1'b0);
    send_image();
    img.delete();
    img.push_back(CHAR_COLON);
    put_byte(8'h01);
    put_byte(8'h00);
    send_image();
    img.delete();
    img.push_back(8'h41);
    img.push_back(8'h0A);
    send_image();
  endtask

  task automatic test_window_limits();
    wait_idle();
    write_reg(REG_APP_BASE, 32'h0000_0000);
    write_reg(REG_APP_END, 32'hFFFF_FFFF);
    windows_used++;
    glyph_case = CASE_LOWER;
    img.delete();
    payload.delete();
    payload.push_back(8'h00);
    put_record(REC_DATA, 16'h0000, 1'b0);
    put_ext(16'hFFFF);
    payload.delete();
    payload.push_back(8'hFF);
    put_record(REC_DATA, 16'hFFFE, 1'b0);
    payload.delete();
    put_record(REC_EOF, 16'h0000, 1'b0);
    send_image();
    // This record would end one past the top of the address space.
    img.delete();
    put_ext(16'hFFFF);
    payload.delete();
    payload.push_back(8'h5A);
    put_record(REC_DATA, 16'hFFFF, 1'b0);
    send_image();
  endtask

  task automatic run_random_phase(input logic [31:0] base, input logic [31:0] stop,
                                  input int budget);
    int start;
    wait_idle();
    write_reg(REG_APP_BASE, base);
    write_reg(REG_APP_END, stop);
    windows_used++;
    start = chars_sent;
    while (chars_sent - start < budget) begin
      gen_image();
      send_image();
    end
  endtask

  task automatic test_random_traffic();
    logic [31:0] b;
    run_random_phase(APP_BASE_RESET, APP_END_RESET, 100);
    run_random_phase(32'h0000_0000, 32'hFFFF_FFFF, 60);
    run_random_phase(32'hFFFF_0000, 32'hFFFF_FFFF, 40);
    b = $urandom;
    run_random_phase(b, b + 32'($urandom_range(1, 64)), 40);
    b = $urandom;
    run_random_phase(b, b - 32'($urandom_range(0, 4096)), 30);
    b = $urandom & 32'hFFF0_0000;
    run_random_phase(b, b + 32'($urandom_range(65536, 1 << 20)), 30);
  endtask

  // The receiver holds off for a long stretch while the sender keeps the input busy.
  task automatic test_backpressure();
    int start;
    wait_idle();
    hold_req = 1'b1;
    while (hold_left == 0) @(posedge clk);
    burst_left = LONG_HOLD + 100;
    start = chars_sent;
    while (chars_sent - start < 40) begin
      gen_image();
      send_image();
    end
  endtask

  initial begin
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_clean_image();
    test_record_errors();
    test_window_limits();
    test_random_traffic();
    test_backpressure();
    sender_idle();
    for (int i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      error_count += pending_results.size();
    end
    $display("Sent %0d characters in %0d images across %0d address windows, with %0d failures.",
             chars_sent, images_sent, windows_used, error_count);
    $display("Saw %0d data bytes, %0d accepted records, %0d complete images, %0d format and %0d %s",
             n_data, n_accept, n_done, n_fmt, n_range, "range errors.");
    if (error_count == 0) begin
      $display("tb_intel_hex_record_checker passed");
    end else begin
      $display("tb_intel_hex_record_checker failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ihc_pkg.sv
sv/ihc_cfg_regs.sv
sv/ihc_step.sv
sv/intel_hex_record_checker.sv
tb/tb_intel_hex_record_checker.sv
